### rtl/u16550_pkg.sv
// ----------------------------------------------------------------------------
// u16550_pkg
// shared types and codes for the 16550-subset uart register block
// ----------------------------------------------------------------------------
package u16550_pkg;

  // item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_RX    = 2'd2;

  // legal access sizes in bytes
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  // register offsets
  localparam logic [2:0] OFF_RBR_THR = 3'd0;
  localparam logic [2:0] OFF_IER     = 3'd1;
  localparam logic [2:0] OFF_IIR_FCR = 3'd2;
  localparam logic [2:0] OFF_LCR     = 3'd3;
  localparam logic [2:0] OFF_MCR     = 3'd4;
  localparam logic [2:0] OFF_LSR     = 3'd5;
  localparam logic [2:0] OFF_MSR     = 3'd6;
  localparam logic [2:0] OFF_SCR     = 3'd7;

  // ier bits
  localparam int IER_RX_BIT   = 0;
  localparam int IER_THRE_BIT = 1;

  // iir codes
  localparam logic [7:0] IIR_NONE = 8'h01;
  localparam logic [7:0] IIR_THRE = 8'h02;
  localparam logic [7:0] IIR_RX   = 8'h04;

  // lsr bits
  localparam logic [7:0] LSR_DR   = 8'h01;
  localparam logic [7:0] LSR_THRE = 8'h20;
  localparam logic [7:0] LSR_TEMT = 8'h40;

  // fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_LOAD  = 2'd1;
  localparam logic [1:0] FAULT_STORE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_offset;
    logic [2:0] access_size;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] fault;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_taken;
    logic       irq_level;
  } result_t;

endpackage

### rtl/u16550_in_stage.sv
// ----------------------------------------------------------------------------
// u16550_in_stage
// input register: captures one item per cycle from the command port
// ----------------------------------------------------------------------------
module u16550_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  u16550_pkg::item_t  item_in,
  output logic               item_valid,
  output u16550_pkg::item_t  item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

endmodule

### rtl/u16550_core.sv
// ----------------------------------------------------------------------------
// u16550_core
// register state, access decode and result register
// ----------------------------------------------------------------------------
module u16550_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  u16550_pkg::item_t    item,
  output logic                 done,
  output u16550_pkg::result_t  result
);

  logic [7:0] rx_hold;
  logic       rx_full;
  logic [7:0] int_enable;
  logic [7:0] line_control;
  logic [7:0] modem_control;
  logic [7:0] scratch;
  logic       thre_cause;
  logic       irq_line;

  logic [7:0] rx_hold_next;
  logic       rx_full_next;
  logic [7:0] int_enable_next;
  logic [7:0] line_control_next;
  logic [7:0] modem_control_next;
  logic [7:0] scratch_next;
  logic       thre_cause_next;
  logic       irq_line_next;

  u16550_pkg::result_t result_next;
  logic       size_ok;
  logic       rx_cause;
  logic       thre_active;

  assign size_ok = (item.access_size == u16550_pkg::SIZE_BYTE) ||
                   (item.access_size == u16550_pkg::SIZE_WORD);
  assign rx_cause    = int_enable[u16550_pkg::IER_RX_BIT] & rx_full;
  assign thre_active = int_enable[u16550_pkg::IER_THRE_BIT] & thre_cause;

  always_comb begin
    rx_hold_next       = rx_hold;
    rx_full_next       = rx_full;
    int_enable_next    = int_enable;
    line_control_next  = line_control;
    modem_control_next = modem_control;
    scratch_next       = scratch;
    thre_cause_next    = thre_cause;
    result_next        = '0;

    unique case (item.kind)
      u16550_pkg::KIND_READ: begin
        if (!size_ok) begin
          result_next.fault = u16550_pkg::FAULT_LOAD;
        end else begin
          unique case (item.reg_offset)
            u16550_pkg::OFF_RBR_THR: begin
              result_next.read_data = rx_full ? rx_hold : 8'h00;
              rx_full_next = 1'b0;
            end
            u16550_pkg::OFF_IER: result_next.read_data = int_enable;
            u16550_pkg::OFF_IIR_FCR: begin
              if (rx_cause) begin
                result_next.read_data = u16550_pkg::IIR_RX;
              end else if (thre_active) begin
                // reading iir acks only the transmit cause
                result_next.read_data = u16550_pkg::IIR_THRE;
                thre_cause_next = 1'b0;
              end else begin
                result_next.read_data = u16550_pkg::IIR_NONE;
              end
            end
            u16550_pkg::OFF_LCR: result_next.read_data = line_control;
            u16550_pkg::OFF_MCR: result_next.read_data = modem_control;
            u16550_pkg::OFF_LSR: begin
              result_next.read_data = u16550_pkg::LSR_THRE | u16550_pkg::LSR_TEMT |
                                      (rx_full ? u16550_pkg::LSR_DR : 8'h00);
            end
            u16550_pkg::OFF_SCR: result_next.read_data = scratch;
            default: result_next.read_data = 8'h00;
          endcase
        end
      end
      u16550_pkg::KIND_WRITE: begin
        if (!size_ok) begin
          result_next.fault = u16550_pkg::FAULT_STORE;
        end else begin
          unique case (item.reg_offset)
            u16550_pkg::OFF_RBR_THR: begin
              // transmitter is always empty: byte leaves at once
              result_next.tx_valid = 1'b1;
              result_next.tx_byte  = item.write_data;
              thre_cause_next      = 1'b1;
            end
            u16550_pkg::OFF_IER: begin
              int_enable_next = item.write_data;
              if (item.write_data[u16550_pkg::IER_THRE_BIT]) begin
                thre_cause_next = 1'b1;
              end
            end
            u16550_pkg::OFF_LCR: line_control_next  = item.write_data;
            u16550_pkg::OFF_MCR: modem_control_next = item.write_data;
            u16550_pkg::OFF_SCR: scratch_next       = item.write_data;
            default: ;
          endcase
        end
      end
      u16550_pkg::KIND_RX: begin
        if (!rx_full) begin
          rx_hold_next         = item.rx_byte;
          rx_full_next         = 1'b1;
          result_next.rx_taken = 1'b1;
        end
      end
      default: ;
    endcase

    irq_line_next = (int_enable_next[u16550_pkg::IER_RX_BIT] & rx_full_next) |
                    (int_enable_next[u16550_pkg::IER_THRE_BIT] & thre_cause_next);
    result_next.irq_level = irq_line_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_full       <= 1'b0;
      int_enable    <= 8'h00;
      line_control  <= 8'h00;
      modem_control <= 8'h00;
      scratch       <= 8'h00;
      thre_cause    <= 1'b0;
      irq_line      <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= item_valid;
      if (item_valid) begin
        rx_full       <= rx_full_next;
        int_enable    <= int_enable_next;
        line_control  <= line_control_next;
        modem_control <= modem_control_next;
        scratch       <= scratch_next;
        thre_cause    <= thre_cause_next;
        irq_line      <= irq_line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      rx_hold <= rx_hold_next;
      result  <= result_next;
    end
  end

  // a faulted access must have no side effects on the line
  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    done && (result.fault != u16550_pkg::FAULT_NONE) |-> !result.tx_valid && !result.rx_taken)
    else $error("faulted item transmitted or took a byte");

  // a stored byte leaves the slot full
  a_rx_full: assert property (@(posedge clk) disable iff (rst)
    done && result.rx_taken |-> rx_full)
    else $error("rx byte taken but slot not full");

  // a transmit always raises the transmit cause
  a_tx_cause: assert property (@(posedge clk) disable iff (rst)
    done && result.tx_valid |-> thre_cause)
    else $error("transmit without thre cause");

  // reported level matches the stored interrupt line
  a_irq_match: assert property (@(posedge clk) disable iff (rst)
    done |-> result.irq_level == irq_line)
    else $error("irq level differs from stored line");

endmodule

### rtl/uart_16550_register_block.sv
// ----------------------------------------------------------------------------
// uart_16550_register_block
// 16550-subset uart register block with an always empty transmitter
// ----------------------------------------------------------------------------
// Items are taken on any cycle with start high; busy never rises, so one item
// per clock is sustained. The accepting edge loads the input register and the
// next edge loads the result register, so each item gives exactly one result
// on the ports from the result register, marked by done high for a single
// cycle and taken at the edge after it. The receiver must take it then, since
// results cannot be held off. Those two register stages frame the path;
// decode and flag update sit between them.
module uart_16550_register_block (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [2:0] reg_offset,
  input  logic [2:0] access_size,
  input  logic [7:0] write_data,
  input  logic [7:0] rx_byte,
  output logic       done,
  output logic [7:0] read_data,
  output logic [1:0] fault,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       rx_taken,
  output logic       irq_level
);

  u16550_pkg::item_t   item_in;
  u16550_pkg::item_t   item;
  u16550_pkg::result_t result;
  logic                item_valid;

  assign busy = 1'b0;

  assign item_in.kind        = kind;
  assign item_in.reg_offset  = reg_offset;
  assign item_in.access_size = access_size;
  assign item_in.write_data  = write_data;
  assign item_in.rx_byte     = rx_byte;

  u16550_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .accept     (start && !busy),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item       (item)
  );

  u16550_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .done       (done),
    .result     (result)
  );

  assign read_data = result.read_data;
  assign fault     = result.fault;
  assign tx_valid  = result.tx_valid;
  assign tx_byte   = result.tx_byte;
  assign rx_taken  = result.rx_taken;
  assign irq_level = result.irq_level;

endmodule
